// ===== hdl/lptc_pkg.sv =====
// Shared types and constants of the luma tone curve block: pixel words, the
// configuration bundle, matrix coefficients and register indexes.
// No dependencies; every other file of the block imports it.
package lptc_pkg;

  // Field widths of the pixel words and the registers.
  localparam int PIX_W     = 8;
  localparam int KNEE_W    = 10;
  localparam int GAIN_W    = 12;
  localparam int NUM_KNEES = 4;
  localparam int NUM_GAINS = 3;

  // Datapath widths that do not depend on the luma precision.
  localparam int COEF_W = 18;              // signed Q16 matrix coefficients
  localparam int MAC_W  = 29;              // three 18x9 products summed
  localparam int SY_W   = 24;              // weighted luma sum, unsigned
  localparam int CH_W   = 26;              // U and V in Q16, signed
  localparam int CPW    = CH_W + COEF_W;   // one chroma product
  localparam int GSW    = CPW + 1;         // sum of two chroma products
  localparam int ACC_W  = 56;              // Q32 channel accumulators

  // Division by 255: reciprocal scaled by 2^32, rounded down.
  localparam int               RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'd16843009;
  // Half of the divisor 255 * 2^16.
  localparam int HALF_DEN = 8355840;

  // Forward matrix, signed Q16.
  localparam logic signed [COEF_W-1:0] CY_R = 18'sd19556;
  localparam logic signed [COEF_W-1:0] CY_G = 18'sd38502;
  localparam logic signed [COEF_W-1:0] CY_B = 18'sd7484;
  localparam logic signed [COEF_W-1:0] CU_R = -18'sd11076;
  localparam logic signed [COEF_W-1:0] CU_G = -18'sd21810;
  localparam logic signed [COEF_W-1:0] CU_B = 18'sd32893;
  localparam logic signed [COEF_W-1:0] CV_R = 18'sd32847;
  localparam logic signed [COEF_W-1:0] CV_G = -18'sd27499;
  localparam logic signed [COEF_W-1:0] CV_B = -18'sd5341;
  // Back conversion, signed Q16.
  localparam logic signed [COEF_W-1:0] CR_V = 18'sd91750;
  localparam logic signed [COEF_W-1:0] CG_U = -18'sd22479;
  localparam logic signed [COEF_W-1:0] CG_V = -18'sd46596;
  localparam logic signed [COEF_W-1:0] CB_U = 18'sd115671;

  // Configuration port.
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KNEE_ONE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KNEE_TWO      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KNEE_THREE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KNEE_FOUR     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SEG_ONE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SEG_TWO   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SEG_THREE = 3'd6;

  // Reset values of the registers.
  localparam logic [KNEE_W-1:0] KNEE_ONE_RST   = 10'd205;
  localparam logic [KNEE_W-1:0] KNEE_TWO_RST   = 10'd512;
  localparam logic [KNEE_W-1:0] KNEE_THREE_RST = 10'd614;
  localparam logic [KNEE_W-1:0] KNEE_FOUR_RST  = 10'd819;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 12'd256;

  // Input and output pixel words.
  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
  } pix_out_t;

  // Register contents handed from the register file to the datapath.
  typedef struct packed {
    logic [NUM_KNEES-1:0][KNEE_W-1:0] knee;
    logic [NUM_GAINS-1:0][GAIN_W-1:0] gain;
  } lptc_cfg_t;

  // Chroma terms of the back conversion, carried down the pipeline.
  typedef struct packed {
    logic signed [GSW-1:0] red_v;
    logic signed [GSW-1:0] green_uv;
    logic signed [GSW-1:0] blue_u;
  } chroma_t;

endpackage

// ===== hdl/lptc_regs.sv =====
// Register file of the luma tone curve block behind an APB-style port.
// Depends on lptc_pkg for register indexes, reset values and lptc_cfg_t.
module lptc_regs
  import lptc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lptc_cfg_t          cfg
);

  lptc_cfg_t             cfg_r;
  lptc_cfg_t             cfg_nxt;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write decode; an index past the last register changes nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KNEE_ONE:       cfg_nxt.knee[0] = pwdata[KNEE_W-1:0];
        REG_KNEE_TWO:       cfg_nxt.knee[1] = pwdata[KNEE_W-1:0];
        REG_KNEE_THREE:     cfg_nxt.knee[2] = pwdata[KNEE_W-1:0];
        REG_KNEE_FOUR:      cfg_nxt.knee[3] = pwdata[KNEE_W-1:0];
        REG_GAIN_SEG_ONE:   cfg_nxt.gain[0] = pwdata[GAIN_W-1:0];
        REG_GAIN_SEG_TWO:   cfg_nxt.gain[1] = pwdata[GAIN_W-1:0];
        REG_GAIN_SEG_THREE: cfg_nxt.gain[2] = pwdata[GAIN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knee[0] <= KNEE_ONE_RST;
      cfg_r.knee[1] <= KNEE_TWO_RST;
      cfg_r.knee[2] <= KNEE_THREE_RST;
      cfg_r.knee[3] <= KNEE_FOUR_RST;
      cfg_r.gain[0] <= GAIN_RST;
      cfg_r.gain[1] <= GAIN_RST;
      cfg_r.gain[2] <= GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_KNEE_ONE:       prdata = 32'(cfg_r.knee[0]);
      REG_KNEE_TWO:       prdata = 32'(cfg_r.knee[1]);
      REG_KNEE_THREE:     prdata = 32'(cfg_r.knee[2]);
      REG_KNEE_FOUR:      prdata = 32'(cfg_r.knee[3]);
      REG_GAIN_SEG_ONE:   prdata = 32'(cfg_r.gain[0]);
      REG_GAIN_SEG_TWO:   prdata = 32'(cfg_r.gain[1]);
      REG_GAIN_SEG_THREE: prdata = 32'(cfg_r.gain[2]);
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/lptc_datapath.sv =====
// Eight-stage pixel pipeline of the luma tone curve block: matrix, luma
// division by 255, five-segment curve and back conversion with clamping.
// Depends on lptc_pkg for pixel words, coefficients and the config bundle.
module lptc_datapath
  import lptc_pkg::*;
#(
  parameter int LUMA_FRAC_BITS = 10
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pix_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output pix_out_t  out_data,
  input  lptc_cfg_t cfg
);

  localparam int F    = LUMA_FRAC_BITS;
  localparam int NSTG = 8;
  localparam int NW   = SY_W + F + 1;        // rounded, scaled luma numerator
  localparam int QW   = NW - 16;             // numerator over 2^16
  localparam int PRW  = QW + RECIP_W;        // reciprocal product
  localparam int EW   = PRW - 32;            // quotient estimate
  localparam int YW   = F + 1;               // luma, unsigned
  localparam int SW   = F + 3;               // signed luma and segment lengths
  localparam int GPW  = SW + GAIN_W + 1;     // segment times slope
  localparam int TW   = GPW + 2;             // sum of three products
  localparam int TRW  = TW - 8;              // after rounding off Q8
  localparam int LW   = TRW + 1;             // bent luma
  localparam int CW   = ACC_W - 32;          // integer part of a channel

  localparam logic signed [ACC_W-1:0] HALF_Q32 = ACC_W'(64'sh8000_0000);

  // Pipeline advances whenever the output word is free or being taken.
  logic            en;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];
  assign vld_nxt   = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Alpha rides alongside the colour data through the first seven stages.
  logic [NSTG-2:0][PIX_W-1:0] alpha_r;

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= {alpha_r[NSTG-3:0], in_data.alpha_in};
    end
  end

  // Stage 1: forward matrix.
  logic signed [8:0]       r9, g9, b9;
  logic signed [MAC_W-1:0] sum_y, sum_u, sum_v;
  logic [SY_W-1:0]         sy_r;
  logic signed [CH_W-1:0]  u_r, v_r;

  assign r9    = $signed({1'b0, in_data.red_in});
  assign g9    = $signed({1'b0, in_data.green_in});
  assign b9    = $signed({1'b0, in_data.blue_in});
  assign sum_y = CY_R * r9 + CY_G * g9 + CY_B * b9;
  assign sum_u = CU_R * r9 + CU_G * g9 + CU_B * b9;
  assign sum_v = CV_R * r9 + CV_G * g9 + CV_B * b9;

  always_ff @(posedge clk) begin
    if (en) begin
      sy_r <= sum_y[SY_W-1:0];
      u_r  <= sum_u[CH_W-1:0];
      v_r  <= sum_v[CH_W-1:0];
    end
  end

  // Stage 2: scale luma, multiply by the reciprocal of 255, and form the
  // chroma products of the back conversion.
  logic [NW-1:0]          num;
  logic [QW-1:0]          q_nxt, q_r;
  logic [PRW-1:0]         prod_nxt, prod_r;
  logic signed [CPW-1:0]  rv_r, gu_r, gv_r, bu_r;

  assign num      = NW'({sy_r, {F{1'b0}}}) + NW'(HALF_DEN);
  assign q_nxt    = num[NW-1:16];
  assign prod_nxt = PRW'(q_nxt) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      prod_r <= prod_nxt;
      rv_r   <= CPW'(v_r) * CPW'(CR_V);
      gu_r   <= CPW'(u_r) * CPW'(CG_U);
      gv_r   <= CPW'(v_r) * CPW'(CG_V);
      bu_r   <= CPW'(u_r) * CPW'(CB_U);
    end
  end

  // Stage 3: the estimate is the quotient or one short; the remainder
  // decides which.
  logic [EW-1:0]   est;
  logic [QW:0]     est_x, est255, rem;
  logic            bump;
  logic [YW-1:0]   y_nxt, y_r;
  chroma_t         chr_nxt;
  chroma_t [3:0]   chr_r;

  assign est    = prod_r[PRW-1:32];
  assign est_x  = (QW + 1)'(est);
  assign est255 = (est_x << 8) - est_x;
  assign rem    = {1'b0, q_r} - est255;
  assign bump   = rem >= (QW + 1)'(255);
  assign y_nxt  = YW'(est + EW'(bump));

  assign chr_nxt.red_v    = GSW'(rv_r);
  assign chr_nxt.green_uv = GSW'(gu_r) + GSW'(gv_r);
  assign chr_nxt.blue_u   = GSW'(bu_r);

  // Chroma waits in a short delay line until stage 7 needs it.
  always_ff @(posedge clk) begin
    if (en) begin
      y_r   <= y_nxt;
      chr_r <= {chr_r[2:0], chr_nxt};
    end
  end

  // Stage 4: knees to luma scale, segment lengths and the unit-slope ends.
  logic [NUM_KNEES-1:0][F+9:0]          kx;
  logic signed [NUM_KNEES-1:0][SW-1:0]  ks;
  logic signed [SW-1:0]                 ys, ymin, ymax;
  logic signed [NUM_GAINS-1:0][SW-1:0]  d_nxt, d_r;
  logic signed [SW-1:0]                 low_nxt, low_r;

  function automatic logic signed [SW-1:0] seg_clamp(
    input logic signed [SW-1:0] x,
    input logic signed [SW-1:0] lo,
    input logic signed [SW-1:0] hi
  );
    logic signed [SW-1:0] m;
    m = (x > lo) ? x : lo;
    return (m < hi) ? m : hi;
  endfunction

  for (genvar i = 0; i < NUM_KNEES; i++) begin : g_knee
    assign kx[i] = {cfg.knee[i], {F{1'b0}}};
    assign ks[i] = $signed({{(SW - F){1'b0}}, kx[i][F+9:10]});
  end

  for (genvar j = 0; j < NUM_GAINS; j++) begin : g_seg
    assign d_nxt[j] = seg_clamp(ys, ks[j], ks[j+1]) - ks[j];
  end

  assign ys      = $signed({{(SW - YW){1'b0}}, y_r});
  assign ymin    = (ys < ks[0]) ? ys : ks[0];
  assign ymax    = (ys > ks[NUM_KNEES-1]) ? ys : ks[NUM_KNEES-1];
  assign low_nxt = ymin + ymax - ks[NUM_KNEES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      low_r <= low_nxt;
    end
  end

  // Stage 5: segment lengths times their slopes, Q8. A segment length may
  // be negative when the knees are out of order.
  logic signed [NUM_GAINS-1:0][GPW-1:0] p_r;
  logic signed [SW-1:0]                 low5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        p_r[j] <= GPW'($signed(d_r[j])) * $signed({1'b0, cfg.gain[j]});
      end
      low5_r <= low_r;
    end
  end

  // Stage 6: sum, round off Q8 with ties upward, add the unit-slope ends.
  logic signed [TW-1:0]  t_sum;
  logic signed [TRW-1:0] t_rnd;
  logic signed [LW-1:0]  ylum_nxt, ylum_r;

  assign t_sum    = TW'($signed(p_r[0])) + TW'($signed(p_r[1])) + TW'($signed(p_r[2]));
  assign t_rnd    = TRW'((t_sum + TW'(128)) >>> 8);
  assign ylum_nxt = LW'(low5_r) + LW'(t_rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      ylum_r <= ylum_nxt;
    end
  end

  // Stage 7: luma to Q32 channel units plus the chroma terms.
  logic signed [ACC_W-1:0]        ya, y255, yq;
  logic signed [2:0][ACC_W-1:0]   acc_r;

  assign ya   = ACC_W'(ylum_r);
  assign y255 = (ya <<< 8) - ya;
  assign yq   = y255 <<< (32 - F);

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0] <= yq + ACC_W'(chr_r[3].red_v);
      acc_r[1] <= yq + ACC_W'(chr_r[3].green_uv);
      acc_r[2] <= yq + ACC_W'(chr_r[3].blue_u);
    end
  end

  // Stage 8: negative gives zero, otherwise round and saturate at 255.
  function automatic logic [PIX_W-1:0] to_channel(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] ar;
    logic [CW-1:0]           c;
    ar = a + HALF_Q32;
    c  = ar[ACC_W-1:32];
    if (a[ACC_W-1]) begin
      return '0;
    end else if (c > CW'(255)) begin
      return 8'd255;
    end
    return c[PIX_W-1:0];
  endfunction

  pix_out_t out_nxt, out_r;

  assign out_nxt.red_out   = to_channel(acc_r[0]);
  assign out_nxt.green_out = to_channel(acc_r[1]);
  assign out_nxt.blue_out  = to_channel(acc_r[2]);
  assign out_nxt.alpha_out = alpha_r[NSTG-2];

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/luma_piecewise_tone_curve.sv =====
// Top level of the luma tone curve block: register file and pixel pipeline.
// Depends on lptc_pkg, lptc_regs and lptc_datapath.
//
// Usage: pixels enter on in_valid/in_ready with in_data, one RGBA word of
// 8-bit channels. Each word is converted to luma and chroma, its luma is
// bent by a five-segment curve, and it leaves on out_valid/out_ready with
// out_data, the channels clamped to 0..255 and alpha copied.
// Throughput is one word per cycle while the receiver does not stall. A
// word reaches out_valid through the eight register stages of the
// pipeline, the first of which loads at the accepting edge itself (matrix,
// reciprocal multiply, quotient fix-up, segments, slope multiply, rounding,
// back conversion, clamping).
// When the receiver stalls, the whole pipeline holds; in_ready is low only
// while a result waits unaccepted, so no word is lost or repeated.
// Knees and slopes are written through the APB-style port (psel, penable,
// pwrite, paddr, pwdata, prdata, pready), register i at byte address 4*i.
// Write them only while no word is in flight; the block does not check it.
// Reset empties the pipeline, loads knees 205, 512, 614, 819 and unit slopes.
module luma_piecewise_tone_curve
  import lptc_pkg::*;
#(
  parameter int LUMA_FRAC_BITS = 10
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pix_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pix_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  lptc_cfg_t cfg;

  // Configuration registers.
  lptc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pixel pipeline.
  lptc_datapath #(
    .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg)
  );

endmodule
